// ----- src/integer_execute_unit_macros.svh -----
// Assertion macros used by the integer execute unit top level.
`ifndef INTEGER_EXECUTE_UNIT_MACROS_SVH
`define INTEGER_EXECUTE_UNIT_MACROS_SVH

// Clocked property check, quiet while reset is high.
`define IEXU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression that must never be true on a clock edge.
`define IEXU_NEVER(lbl, expr, msg) \
  `IEXU_ASSERT(lbl, !(expr), msg)

`endif

// ----- src/iexu_pkg.sv -----
// Package with operation codes and the pipeline item type of the execute unit.
`default_nettype none
package iexu_pkg;

  localparam logic [5:0] FN_LUI   = 6'd0;
  localparam logic [5:0] FN_AUIPC = 6'd1;
  localparam logic [5:0] FN_JAL   = 6'd2;
  localparam logic [5:0] FN_JALR  = 6'd3;
  localparam logic [5:0] FN_BEQ   = 6'd4;
  localparam logic [5:0] FN_BNE   = 6'd5;
  localparam logic [5:0] FN_BLT   = 6'd6;
  localparam logic [5:0] FN_BGE   = 6'd7;
  localparam logic [5:0] FN_BLTU  = 6'd8;
  localparam logic [5:0] FN_BGEU  = 6'd9;
  localparam logic [5:0] FN_ADDI  = 6'd10;
  localparam logic [5:0] FN_SLTI  = 6'd11;
  localparam logic [5:0] FN_SLTIU = 6'd12;
  localparam logic [5:0] FN_XORI  = 6'd13;
  localparam logic [5:0] FN_ORI   = 6'd14;
  localparam logic [5:0] FN_ANDI  = 6'd15;
  localparam logic [5:0] FN_SLLI  = 6'd16;
  localparam logic [5:0] FN_SRLI  = 6'd17;
  localparam logic [5:0] FN_SRAI  = 6'd18;
  localparam logic [5:0] FN_ADD   = 6'd19;
  localparam logic [5:0] FN_SUB   = 6'd20;
  localparam logic [5:0] FN_SLL   = 6'd21;
  localparam logic [5:0] FN_SLT   = 6'd22;
  localparam logic [5:0] FN_SLTU  = 6'd23;
  localparam logic [5:0] FN_XOR   = 6'd24;
  localparam logic [5:0] FN_SRL   = 6'd25;
  localparam logic [5:0] FN_SRA   = 6'd26;
  localparam logic [5:0] FN_OR    = 6'd27;
  localparam logic [5:0] FN_AND   = 6'd28;
  localparam logic [5:0] FN_MUL   = 6'd29;
  localparam logic [5:0] FN_DIV   = 6'd30;
  localparam logic [5:0] FN_ROT   = 6'd31;
  localparam logic [5:0] FN_ADDR  = 6'd32;

  localparam int DivSteps = 32;

  typedef struct packed {
    logic [31:0] result;
    logic        writes_reg;
    logic        taken;
    logic [31:0] next_pc;
    logic [31:0] mem_address;
    logic        bad_op;
    logic        div_run;
    logic        div_neg;
    logic [31:0] rem;
    logic [31:0] quo;
    logic [31:0] dvsr;
  } pipe_t;

endpackage
`default_nettype wire

// ----- src/iexu_front.sv -----
// Decode stage with the ALU, branch, multiply and divide setup.
`default_nettype none
module iexu_front (
  input  logic               clk,
  input  logic               rst,
  input  logic [3:0]         pc_step,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [5:0]         func,
  input  logic [31:0]        operand_a,
  input  logic [31:0]        operand_b,
  input  logic [31:0]        imm,
  input  logic [31:0]        pc,
  output logic               out_valid,
  input  logic               out_ready,
  output iexu_pkg::pipe_t    out_item
);
  import iexu_pkg::*;

  pipe_t       item;
  logic [31:0] seq;
  logic [31:0] br_target;
  logic [31:0] a_plus_imm;
  logic [31:0] prod;
  logic        cond;
  logic [31:0] mag_a;
  logic [31:0] mag_b;

  assign seq        = pc + {28'd0, pc_step};
  assign br_target  = pc + imm;
  assign a_plus_imm = operand_a + imm;
  assign prod       = operand_a * operand_b;
  assign mag_a      = operand_a[31] ? (32'd0 - operand_a) : operand_a;
  assign mag_b      = operand_b[31] ? (32'd0 - operand_b) : operand_b;

  always_comb begin
    item             = '0;
    item.writes_reg  = 1'b1;
    item.next_pc     = seq;
    item.rem         = '0;
    item.quo         = mag_a;
    item.dvsr        = mag_b;
    item.div_neg     = operand_a[31] ^ operand_b[31];
    cond             = 1'b0;
    case (func)
      FN_LUI:   item.result = imm;
      FN_AUIPC: item.result = br_target;
      FN_JAL: begin
        item.result  = seq;
        item.taken   = 1'b1;
        item.next_pc = br_target;
      end
      FN_JALR: begin
        item.result  = seq;
        item.taken   = 1'b1;
        item.next_pc = a_plus_imm;
      end
      FN_BEQ, FN_BNE, FN_BLT, FN_BGE, FN_BLTU, FN_BGEU: begin
        item.writes_reg = 1'b0;
        case (func)
          FN_BEQ:  cond = operand_a == operand_b;
          FN_BNE:  cond = operand_a != operand_b;
          FN_BLT:  cond = $signed(operand_a) < $signed(operand_b);
          FN_BGE:  cond = !($signed(operand_a) < $signed(operand_b));
          FN_BLTU: cond = operand_a < operand_b;
          default: cond = !(operand_a < operand_b);
        endcase
        if (cond) begin
          item.taken   = 1'b1;
          item.next_pc = br_target;
        end
      end
      FN_ADDI:  item.result = a_plus_imm;
      FN_SLTI:  item.result = {31'd0, $signed(operand_a) < $signed(imm)};
      FN_SLTIU: item.result = {31'd0, operand_a < imm};
      FN_XORI:  item.result = operand_a ^ imm;
      FN_ORI:   item.result = operand_a | imm;
      FN_ANDI:  item.result = operand_a & imm;
      FN_SLLI:  item.result = operand_a << imm[4:0];
      FN_SRLI:  item.result = operand_a >> imm[4:0];
      FN_SRAI:  item.result = $unsigned($signed(operand_a) >>> imm[4:0]);
      FN_ADD:   item.result = operand_a + operand_b;
      FN_SUB:   item.result = operand_a - operand_b;
      FN_SLL:   item.result = operand_a << operand_b[4:0];
      FN_SLT:   item.result = {31'd0, $signed(operand_a) < $signed(operand_b)};
      FN_SLTU:  item.result = {31'd0, operand_a < operand_b};
      FN_XOR:   item.result = operand_a ^ operand_b;
      FN_SRL:   item.result = operand_a >> operand_b[4:0];
      FN_SRA:   item.result = $unsigned($signed(operand_a) >>> operand_b[4:0]);
      FN_OR:    item.result = operand_a | operand_b;
      FN_AND:   item.result = operand_a & operand_b;
      FN_MUL:   item.result = prod;
      FN_DIV: begin
        // Division by zero and the one overflow case bypass the divider.
        if (operand_b == 32'd0) begin
          item.result = 32'hFFFF_FFFF;
        end else if (operand_a == 32'h8000_0000 && operand_b == 32'hFFFF_FFFF) begin
          item.result = operand_a;
        end else begin
          item.div_run = 1'b1;
        end
      end
      FN_ROT: item.result = {operand_a[7:0], operand_a[15:8],
                             operand_a[23:16], operand_a[31:24]};
      FN_ADDR: begin
        item.writes_reg  = 1'b0;
        item.mem_address = a_plus_imm;
      end
      default: begin
        item.writes_reg = 1'b0;
        item.bad_op     = 1'b1;
      end
    endcase
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item;
    end
  end

endmodule
`default_nettype wire

// ----- src/iexu_div_step.sv -----
// One restoring division step: retires one quotient bit per stage.
`default_nettype none
module iexu_div_step (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  iexu_pkg::pipe_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output iexu_pkg::pipe_t out_item
);
  import iexu_pkg::*;

  pipe_t       item;
  logic [32:0] partial;
  logic [32:0] diff;

  assign partial = {in_data.rem, in_data.quo[31]};
  assign diff    = partial - {1'b0, in_data.dvsr};

  always_comb begin
    item = in_data;
    if (!diff[32]) begin
      item.rem = diff[31:0];
      item.quo = {in_data.quo[30:0], 1'b1};
    end else begin
      item.rem = partial[31:0];
      item.quo = {in_data.quo[30:0], 1'b0};
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item;
    end
  end

endmodule
`default_nettype wire

// ----- src/iexu_back.sv -----
// Quotient sign fix-up and the output register of the execute unit.
`default_nettype none
module iexu_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  iexu_pkg::pipe_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [98:0]     out_bits
);
  import iexu_pkg::*;

  logic [31:0] res;

  always_comb begin
    res = in_data.result;
    if (in_data.div_run) begin
      res = in_data.div_neg ? (32'd0 - in_data.quo) : in_data.quo;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_bits <= {in_data.bad_op, in_data.mem_address, in_data.next_pc,
                   in_data.taken, in_data.writes_reg, res};
    end
  end

endmodule
`default_nettype wire

// ----- src/integer_execute_unit.sv -----
// Top level of the pipelined integer execute unit.
//
//   channel   dir  handshake                      contents
//   s_axis    in   s_axis_tvalid/s_axis_tready    operation item
//   m_axis    out  m_axis_tvalid/m_axis_tready    result item
//   cfg       in   cfg_valid/cfg_ready            pc_step write
//
// Every operation passes through one decode/ALU stage, 32 divider stages
// that retire one quotient bit each, and one output stage.
// One item is accepted per cycle when the output side keeps up.
// Each stage holds its item until the next has room, so a stall only fills
// bubbles and loses nothing. Reset clears all valid bits and sets pc_step to 4.
`default_nettype none
`include "integer_execute_unit_macros.svh"
module integer_execute_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // func[5:0], operand_a[37:6], operand_b[69:38], imm[101:70], pc[133:102]
  input  logic [135:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // result[31:0], writes_reg[32], taken[33], next_pc[65:34],
  // mem_address[97:66], bad_op[98]
  output logic [103:0]  m_axis_tdata,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [3:0]    cfg_data
);
  import iexu_pkg::*;

  logic [3:0]  pc_step;
  pipe_t       stage_data  [DivSteps+1];
  logic        stage_valid [DivSteps+1];
  logic        stage_ready [DivSteps+1];
  logic [98:0] out_bits;
  logic        bad_side_fx;
  logic        addr_with_write;
  logic        out_stalled;
  logic        last_stalled;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc_step <= 4'd4;
    end else if (cfg_valid) begin
      pc_step <= cfg_data;
    end
  end

  iexu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pc_step   (pc_step),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .func      (s_axis_tdata[5:0]),
    .operand_a (s_axis_tdata[37:6]),
    .operand_b (s_axis_tdata[69:38]),
    .imm       (s_axis_tdata[101:70]),
    .pc        (s_axis_tdata[133:102]),
    .out_valid (stage_valid[0]),
    .out_ready (stage_ready[0]),
    .out_item  (stage_data[0])
  );

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    iexu_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[k]),
      .in_ready  (stage_ready[k]),
      .in_data   (stage_data[k]),
      .out_valid (stage_valid[k+1]),
      .out_ready (stage_ready[k+1]),
      .out_item  (stage_data[k+1])
    );
  end

  iexu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stage_valid[DivSteps]),
    .in_ready  (stage_ready[DivSteps]),
    .in_data   (stage_data[DivSteps]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_bits  (out_bits)
  );

  assign m_axis_tdata = {5'd0, out_bits};

  assign bad_side_fx = m_axis_tvalid && m_axis_tdata[98] &&
                       (m_axis_tdata[32] || m_axis_tdata[33] || m_axis_tdata[97:66] != 32'd0);
  assign addr_with_write = m_axis_tvalid && m_axis_tdata[32] && m_axis_tdata[97:66] != 32'd0;
  assign out_stalled  = m_axis_tvalid && !m_axis_tready;
  assign last_stalled = stage_valid[DivSteps] && !stage_ready[DivSteps];

  // An undefined code never writes, jumps or produces an address.
  `IEXU_NEVER(a_bad_quiet, bad_side_fx, "bad_op item has side effects")
  // Only address generation gives an address, and it never writes a register.
  `IEXU_NEVER(a_addr_nowrite, addr_with_write, "register write with memory address")
  // A stalled result stays put while the output waits.
  `IEXU_ASSERT(a_out_hold, out_stalled |=> $stable({m_axis_tvalid, m_axis_tdata}), "output moved")
  // The divider chain never drops an item that the next stage cannot take.
  `IEXU_ASSERT(a_last_hold, last_stalled |=> stage_valid[DivSteps], "divider item lost")

endmodule
`default_nettype wire

// ----- bench/integer_execute_unit_test.sv -----
// Self-checking testbench for the integer execute unit: directed and random items.
`timescale 1ns / 1ps
module integer_execute_unit_test;
  import iexu_pkg::*;

  localparam int LATENCY = 34;
  localparam int CYCLE_LIMIT = 200000;

  // Declared from the highest bit down so that result sits in the low bits.
  typedef struct packed {
    logic        bad_op;
    logic [31:0] mem_address;
    logic [31:0] next_pc;
    logic        taken;
    logic        writes_reg;
    logic [31:0] result;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_data = '0;

  logic [3:0] step_size = 4'd4;
  outcome_t pending_outcomes[$];
  int error_count = 0;
  int cycle_count = 0;
  bit hold_sink = 1'b0;
  bit no_idle = 1'b0;

  integer_execute_unit i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic outcome_t execute(logic [5:0] func, logic [31:0] a, logic [31:0] b,
                                       logic [31:0] imm, logic [31:0] pc);
    outcome_t o;
    logic [31:0] seq;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] q;
    logic cond;
    seq = pc + {28'd0, step_size};
    o = '0;
    o.writes_reg = 1'b1;
    o.next_pc = seq;
    cond = 1'b0;
    case (func)
      FN_LUI:   o.result = imm;
      FN_AUIPC: o.result = pc + imm;
      FN_JAL: begin
        o.result = seq; o.taken = 1'b1; o.next_pc = pc + imm;
      end
      FN_JALR: begin
        o.result = seq; o.taken = 1'b1; o.next_pc = a + imm;
      end
      FN_BEQ, FN_BNE, FN_BLT, FN_BGE, FN_BLTU, FN_BGEU: begin
        o.writes_reg = 1'b0;
        case (func)
          FN_BEQ:  cond = (a == b);
          FN_BNE:  cond = (a != b);
          FN_BLT:  cond = ($signed(a) < $signed(b));
          FN_BGE:  cond = !($signed(a) < $signed(b));
          FN_BLTU: cond = (a < b);
          default: cond = (a >= b);
        endcase
        if (cond) begin
          o.taken = 1'b1; o.next_pc = pc + imm;
        end
      end
      FN_ADDI:  o.result = a + imm;
      FN_SLTI:  o.result = {31'd0, $signed(a) < $signed(imm)};
      FN_SLTIU: o.result = {31'd0, a < imm};
      FN_XORI:  o.result = a ^ imm;
      FN_ORI:   o.result = a | imm;
      FN_ANDI:  o.result = a & imm;
      FN_SLLI:  o.result = a << imm[4:0];
      FN_SRLI:  o.result = a >> imm[4:0];
      FN_SRAI:  o.result = $signed(a) >>> imm[4:0];
      FN_ADD:   o.result = a + b;
      FN_SUB:   o.result = a - b;
      FN_SLL:   o.result = a << b[4:0];
      FN_SLT:   o.result = {31'd0, $signed(a) < $signed(b)};
      FN_SLTU:  o.result = {31'd0, a < b};
      FN_XOR:   o.result = a ^ b;
      FN_SRL:   o.result = a >> b[4:0];
      FN_SRA:   o.result = $signed(a) >>> b[4:0];
      FN_OR:    o.result = a | b;
      FN_AND:   o.result = a & b;
      FN_MUL:   o.result = a * b;
      FN_DIV: begin
        if (b == 32'd0) o.result = '1;
        else if (a == 32'h8000_0000 && b == '1) o.result = a;
        else begin
          ma = a[31] ? -a : a;
          mb = b[31] ? -b : b;
          q = ma / mb;
          o.result = (a[31] ^ b[31]) ? -q : q;
        end
      end
      FN_ROT:   o.result = {a[7:0], a[15:8], a[23:16], a[31:24]};
      FN_ADDR: begin
        o.writes_reg = 1'b0; o.mem_address = a + imm;
      end
      default: begin
        o.writes_reg = 1'b0; o.bad_op = 1'b1;
      end
    endcase
    return o;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch in %s: got %h, expected %h", what, got, want);
    error_count++;
  endtask

  // Result checker; the sink stalls in bursts unless held or told not to idle.
  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[98:0];
      if (pending_outcomes.size() == 0) begin
        $display("result item with no expectation waiting");
        error_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (got.result !== want.result) report("result", got.result, want.result);
        if (got.writes_reg !== want.writes_reg)
          report("writes_reg", got.writes_reg, want.writes_reg);
        if (got.taken !== want.taken) report("taken", got.taken, want.taken);
        if (got.next_pc !== want.next_pc) report("next_pc", got.next_pc, want.next_pc);
        if (got.mem_address !== want.mem_address)
          report("mem_address", got.mem_address, want.mem_address);
        if (got.bad_op !== want.bad_op) report("bad_op", got.bad_op, want.bad_op);
      end
    end
  end

  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (hold_sink) m_axis_tready <= 1'b0;
      else if (!no_idle && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 5);
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
        m_axis_tready <= !hold_sink;
      end else m_axis_tready <= 1'b1;
    end
  end

  // Valid stays high from one item to the next; it drops only for an idle
  // burst or when the stream is drained.
  task automatic send_item(logic [5:0] func, logic [31:0] a, logic [31:0] b,
                           logic [31:0] imm, logic [31:0] pc);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tdata <= {2'b00, pc, imm, b, a, func};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    pending_outcomes.push_back(execute(func, a, b, imm, pc));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_step(logic [3:0] value);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    step_size = value;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(0, 40);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    logic [5:0] f;
    send_item(FN_LUI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_F000, 32'hFFFF_FFFF);
    send_item(FN_JALR, 32'h1001, 0, 32'h7FF, 32'hFFFF_FFFC);
    send_item(FN_SRAI, 32'h8000_0000, 0, 32'hFFFF_FFFF, 32'h0);
    send_item(FN_SLLI, 32'h1, 0, 32'h25, 32'h100);
    send_item(FN_SRA, 32'h8000_0000, 32'h20, 0, 32'h0);
    send_item(FN_DIV, 32'h1234, 32'h0, 0, 32'h0);
    send_item(FN_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 0, 32'h0);
    send_item(FN_DIV, 32'hFFFF_FFF9, 32'h2, 0, 32'h0);
    send_item(FN_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'h0);
    send_item(FN_BLT, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFF0, 32'h40);
    send_item(FN_BLTU, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFF0, 32'h40);
    send_item(6'd33, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8);
    send_item(6'd63, 0, 0, 0, 32'hFFFF_FFFF);
    for (int i = 0; i <= 32; i++) begin
      f = 6'(i);
      send_item(f, pick_word(), pick_word(), pick_word(), pick_word());
    end
    drain();
  endtask

  task automatic test_random(int count);
    logic [5:0] f;
    logic [31:0] a;
    logic [31:0] b;
    for (int i = 0; i < count; i++) begin
      f = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(33, 63)) : 6'($urandom_range(0, 32));
      a = pick_word();
      b = ($urandom_range(0, 3) == 0) ? a : pick_word();
      send_item(f, a, b, pick_word(), pick_word());
    end
  endtask

  // The sink holds off for a long stretch so the pipeline fills and stalls input.
  task automatic test_backpressure();
    fork
      begin
        hold_sink = 1'b1;
        repeat (120) @(posedge clk);
        hold_sink = 1'b0;
      end
      test_random(80);
    join
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    write_step(4'd1);
    test_random(150);
    drain();
    write_step(4'd8);
    test_backpressure();
    write_step(4'd0);
    test_random(100);
    drain();
    write_step(4'd15);
    test_random(100);
    drain();
    write_step(4'd4);
    no_idle = 1'b1;
    test_random(150);
    drain();
    if (error_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+src
src/iexu_pkg.sv
src/iexu_front.sv
src/iexu_div_step.sv
src/iexu_back.sv
src/integer_execute_unit.sv
bench/integer_execute_unit_test.sv
